>>> rtl/otp_pkg.sv
// Shared types and constants for the one-shot timer pool.
`default_nettype none

package otp_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int SLOT_W = 4;
  localparam int TICK_W = 32;
  localparam int TAG_W = 32;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_CREATED  = 3'd0,
    KIND_REFUSED  = 3'd1,
    KIND_DELETED  = 3'd2,
    KIND_EXPIRED  = 3'd3,
    KIND_TICKDONE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_REFUSE,
    ST_DELETE,
    ST_SCAN,
    ST_TICK_DONE
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [TICK_W-1:0] wr_deadline;
    logic [TAG_W-1:0]  wr_tag;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_idx;
    logic [IDX_W-1:0]  rd_idx;
  } store_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             due;
    logic [TAG_W-1:0] tag;
  } store_stat_t;

endpackage

`default_nettype wire

>>> rtl/otp_slot_store.sv
// Slot store: valid bits, deadlines, tags and the shared deadline comparator.
`default_nettype none

module otp_slot_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire otp_pkg::store_ctl_t       ctl,
  input  wire logic [otp_pkg::TICK_W-1:0] tick,
  output otp_pkg::store_stat_t           stat
);

  logic [otp_pkg::SLOTS-1:0]  valid;
  logic [otp_pkg::TICK_W-1:0] deadline_mem [otp_pkg::SLOTS];
  logic [otp_pkg::TAG_W-1:0]  tag_mem [otp_pkg::SLOTS];

  logic clr_in_range;
  assign clr_in_range = ({1'b0, ctl.clr_idx} < (otp_pkg::SLOT_W + 1)'(otp_pkg::SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.wr_en) begin
        valid[ctl.wr_idx] <= 1'b1;
      end
      if (ctl.clr_en && clr_in_range) begin
        valid[otp_pkg::IDX_W'(ctl.clr_idx)] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      deadline_mem[ctl.wr_idx] <= ctl.wr_deadline;
      tag_mem[ctl.wr_idx]      <= ctl.wr_tag;
    end
  end

  // one unsigned compare, shared by every slot over the scan
  always_comb begin
    stat.valid = valid[ctl.rd_idx];
    stat.due   = (deadline_mem[ctl.rd_idx] <= tick);
    stat.tag   = tag_mem[ctl.rd_idx];
  end

endmodule

`default_nettype wire

>>> rtl/one_shot_timer_pool_top.sv
// Top level of the one-shot timer pool: sequencer, tick counter and result register.
// A create walks the slots from slot 0 to the first free one, or through the last slot
// when the pool is full; a delete clears its given slot; a tick scans every slot,
// one slot examined per cycle through the single comparator, then gives tick-done.
// Busy is high outside idle; a new start is taken as soon as busy is low.
// Reset (rst, synchronous): tick count zero, all slots free, no beat pending.
// Results cannot be stalled: each beat shows for one cycle under strobe.
`default_nettype none

module one_shot_timer_pool_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] deadline,
  input  wire logic [31:0] tag,
  input  wire logic [3:0]  slot,
  output logic             strobe,
  output logic [2:0]       kind,
  output logic [3:0]       slot_index,
  output logic [31:0]      user_tag,
  output logic [31:0]      tick_now,
  output logic             last
);

  otp_pkg::state_t state, state_next;

  logic [otp_pkg::IDX_W-1:0]  idx, idx_next;
  logic [otp_pkg::TICK_W-1:0] tick_count;
  logic [otp_pkg::TICK_W-1:0] deadline_q;
  logic [otp_pkg::TAG_W-1:0]  tag_q;
  logic [otp_pkg::SLOT_W-1:0] slot_q;

  // result register, one beat deep; the receiver never stalls
  logic                       strobe_q, strobe_next;
  otp_pkg::kind_t             kind_q, kind_next;
  logic [otp_pkg::SLOT_W-1:0] slot_index_q, slot_index_next;
  logic [otp_pkg::TAG_W-1:0]  user_tag_q, user_tag_next;
  logic                       last_q, last_next;

  otp_pkg::store_ctl_t  ctl;
  otp_pkg::store_stat_t stat;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != otp_pkg::ST_IDLE);

  otp_slot_store u_store (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .tick (tick_count),
    .stat (stat)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      otp_pkg::ST_IDLE: begin
        if (start) begin
          case (otp_pkg::action_t'(action))
            otp_pkg::ACT_CREATE: begin
              // a zero deadline never gets a slot
              state_next = (deadline == '0) ? otp_pkg::ST_REFUSE : otp_pkg::ST_CREATE;
            end
            otp_pkg::ACT_DELETE: state_next = otp_pkg::ST_DELETE;
            otp_pkg::ACT_TICK:   state_next = otp_pkg::ST_SCAN;
            default:             state_next = otp_pkg::ST_IDLE;
          endcase
        end
      end
      otp_pkg::ST_CREATE: begin
        // stop on the first free slot, or after the last slot (pool full)
        if (!stat.valid || idx == otp_pkg::LAST_IDX) begin
          state_next = otp_pkg::ST_IDLE;
        end
      end
      otp_pkg::ST_SCAN: begin
        if (idx == otp_pkg::LAST_IDX) begin
          state_next = otp_pkg::ST_TICK_DONE;
        end
      end
      otp_pkg::ST_REFUSE,
      otp_pkg::ST_DELETE,
      otp_pkg::ST_TICK_DONE: state_next = otp_pkg::ST_IDLE;
      default:               state_next = otp_pkg::ST_IDLE;
    endcase
  end

  // Outputs: store control, slot index and the next result beat
  always_comb begin
    idx_next        = idx;
    strobe_next     = 1'b0;
    kind_next       = otp_pkg::KIND_CREATED;
    slot_index_next = '0;
    user_tag_next   = '0;
    last_next       = 1'b0;

    ctl.wr_en       = 1'b0;
    ctl.wr_idx      = idx;
    ctl.wr_deadline = deadline_q;
    ctl.wr_tag      = tag_q;
    ctl.clr_en      = 1'b0;
    ctl.clr_idx     = otp_pkg::SLOT_W'(idx);
    ctl.rd_idx      = idx;

    case (state)
      otp_pkg::ST_IDLE: begin
        idx_next = '0;
      end
      otp_pkg::ST_CREATE: begin
        if (!stat.valid) begin
          ctl.wr_en       = 1'b1;
          strobe_next     = 1'b1;
          kind_next       = otp_pkg::KIND_CREATED;
          slot_index_next = otp_pkg::SLOT_W'(idx);
          last_next       = 1'b1;
        end else if (idx == otp_pkg::LAST_IDX) begin
          strobe_next = 1'b1;
          kind_next   = otp_pkg::KIND_REFUSED;
          last_next   = 1'b1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      otp_pkg::ST_REFUSE: begin
        strobe_next = 1'b1;
        kind_next   = otp_pkg::KIND_REFUSED;
        last_next   = 1'b1;
      end
      otp_pkg::ST_DELETE: begin
        // an out-of-range or free slot is still reported as deleted
        ctl.clr_en      = 1'b1;
        ctl.clr_idx     = slot_q;
        strobe_next     = 1'b1;
        kind_next       = otp_pkg::KIND_DELETED;
        slot_index_next = slot_q;
        last_next       = 1'b1;
      end
      otp_pkg::ST_SCAN: begin
        if (stat.valid && stat.due) begin
          ctl.clr_en      = 1'b1;
          strobe_next     = 1'b1;
          kind_next       = otp_pkg::KIND_EXPIRED;
          slot_index_next = otp_pkg::SLOT_W'(idx);
          user_tag_next   = stat.tag;
        end
        idx_next = idx + 1'b1;
      end
      otp_pkg::ST_TICK_DONE: begin
        strobe_next = 1'b1;
        kind_next   = otp_pkg::KIND_TICKDONE;
        last_next   = 1'b1;
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= otp_pkg::ST_IDLE;
      idx        <= '0;
      tick_count <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      strobe_q <= strobe_next;
      // advance the counter on acceptance so the scan compares against the new count
      if (accept && otp_pkg::action_t'(action) == otp_pkg::ACT_TICK) begin
        tick_count <= tick_count + 1'b1;
      end
    end
  end

  // Payload registers: hold the accepted item and the pending beat
  always_ff @(posedge clk) begin
    if (accept) begin
      deadline_q <= deadline;
      tag_q      <= tag;
      slot_q     <= slot;
    end
    kind_q       <= kind_next;
    slot_index_q <= slot_index_next;
    user_tag_q   <= user_tag_next;
    last_q       <= last_next;
    // tick count as seen by the beat being formed this cycle
    tick_now     <= tick_count;
  end

  assign strobe     = strobe_q;
  assign kind       = kind_q;
  assign slot_index = slot_index_q;
  assign user_tag   = user_tag_q;
  assign last       = last_q;

  // an accepted action other than the unused code always makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (accept && otp_pkg::action_t'(action) != otp_pkg::ACT_NONE) |=> busy)
    else $error("block not busy after accepting an action");

  // expiry beats are never last; every other beat closes its item
  a_last_by_kind: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (last == (kind != otp_pkg::KIND_EXPIRED)))
    else $error("last flag does not match result kind");

  // the counter moves only on an accepted tick
  a_tick_stable: assert property (@(posedge clk) disable iff (rst)
    !(accept && otp_pkg::action_t'(action) == otp_pkg::ACT_TICK) |=> $stable(tick_count))
    else $error("tick count changed without a tick");

  // no beat appears while idle unless the previous cycle finished an item
  a_strobe_source: assert property (@(posedge clk) disable iff (rst)
    (state == otp_pkg::ST_IDLE) |=> !strobe_q || $past(strobe_next))
    else $error("beat without a finishing step");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the one-shot timer pool top level.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import otp_pkg::*;

  // One result beat as the pool should produce it.
  typedef struct {
    kind_t       kind;
    logic [3:0]  slot_index;
    logic [31:0] user_tag;
    logic [31:0] tick_now;
    logic        last;
  } pool_beat_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic [31:0] deadline;
  logic [31:0] tag;
  logic [3:0]  slot;
  logic        strobe;
  logic [2:0]  kind;
  logic [3:0]  slot_index;
  logic [31:0] user_tag;
  logic [31:0] tick_now;
  logic        last;

  // Shadow copy of the pool, advanced once per accepted item.
  logic [31:0] shadow_ticks;
  logic [15:0] shadow_valid;
  logic [31:0] shadow_deadline [16];
  logic [31:0] shadow_tag [16];

  // Beats still owed by the pool, oldest first.
  pool_beat_t beats_owed[$];
  int         fail_count;

  one_shot_timer_pool_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .deadline   (deadline),
    .tag        (tag),
    .slot       (slot),
    .strobe     (strobe),
    .kind       (kind),
    .slot_index (slot_index),
    .user_tag   (user_tag),
    .tick_now   (tick_now),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Owe one beat, stamped with the shadow tick count after the item.
  task automatic owe_beat(input kind_t k, input logic [3:0] idx, input logic [31:0] tg,
                          input logic lst);
    pool_beat_t b;
    b.kind       = k;
    b.slot_index = idx;
    b.user_tag   = tg;
    b.tick_now   = shadow_ticks;
    b.last       = lst;
    beats_owed.push_back(b);
  endtask

  // Apply one accepted item to the shadow pool and record the beats it causes.
  task automatic pool_apply(input action_t a, input logic [31:0] dl, input logic [31:0] tg,
                            input logic [3:0] sl);
    int  i;
    int  n;
    bit  placed;
    case (a)
      ACT_CREATE: begin
        placed = 1'b0;
        // Zero deadline is refused outright; otherwise take the lowest free slot.
        if (dl != 32'd0) begin
          for (i = 0; i < 16 && !placed; i++) begin
            if (!shadow_valid[4'(i)]) begin
              shadow_valid[4'(i)]    = 1'b1;
              shadow_deadline[4'(i)] = dl;
              shadow_tag[4'(i)]      = tg;
              owe_beat(KIND_CREATED, 4'(i), 32'd0, 1'b1);
              placed = 1'b1;
            end
          end
        end
        if (!placed) owe_beat(KIND_REFUSED, 4'd0, 32'd0, 1'b1);
      end
      ACT_DELETE: begin
        // Deleting a free slot still reports the delete.
        shadow_valid[sl] = 1'b0;
        owe_beat(KIND_DELETED, sl, 32'd0, 1'b1);
      end
      ACT_TICK: begin
        shadow_ticks = shadow_ticks + 32'd1;
        n = 0;
        // Plain unsigned compare: no allowance for wrap of the counter.
        for (i = 0; i < 16 && n < 16; i++) begin
          if (shadow_valid[4'(i)] && shadow_deadline[4'(i)] <= shadow_ticks) begin
            shadow_valid[4'(i)] = 1'b0;
            owe_beat(KIND_EXPIRED, 4'(i), shadow_tag[4'(i)], 1'b0);
            n++;
          end
        end
        owe_beat(KIND_TICKDONE, 4'd0, 32'd0, 1'b1);
      end
      default: begin
        // Unused action: the pool does nothing and owes nothing.
      end
    endcase
  endtask

  // Present one item from a falling edge and hold it until the pool takes it.
  // Leave start high on return; the caller lowers it when a gap follows.
  task automatic send_item(input action_t a, input logic [31:0] dl, input logic [31:0] tg,
                           input logic [3:0] sl);
    start    <= 1'b1;
    action   <= a;
    deadline <= dl;
    tag      <= tg;
    slot     <= sl;
    do @(posedge clk); while (busy);
    pool_apply(a, dl, tg, sl);
    @(negedge clk);
  endtask

  // Idle the sender for a number of cycles.
  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Hold off the sender until every owed beat has come back.
  task automatic drain_pool();
    start <= 1'b0;
    do @(negedge clk); while (beats_owed.size() != 0);
  endtask

  // Compare every strobed beat with the oldest owed one.
  always @(posedge clk) begin
    pool_beat_t want;
    if (!rst && strobe) begin
      if (beats_owed.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected beat: kind %0d slot %0d tag %h tick %h last %b",
                   kind, slot_index, user_tag, tick_now, last);
        fail_count++;
      end else begin
        want = beats_owed.pop_front();
        if (kind !== want.kind || slot_index !== want.slot_index ||
            user_tag !== want.user_tag || tick_now !== want.tick_now ||
            last !== want.last) begin
          if (fail_count < 10)
            $display("mismatch: want kind %0d slot %0d tag %h tick %h last %b, ",
                     want.kind, want.slot_index, want.user_tag, want.tick_now, want.last,
                     "got kind %0d slot %0d tag %h tick %h last %b",
                     kind, slot_index, user_tag, tick_now, last);
          fail_count++;
        end
      end
    end
  end

  // Zero deadline refused; the unused action gives nothing.
  task automatic test_refusals();
    send_item(ACT_CREATE, 32'd0, 32'hFFFF_FFFF, 4'd0);
    send_item(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    drain_pool();
  endtask

  // Fill every slot, overflow the pool, then let fifteen timers fall due on one tick.
  task automatic test_full_pool();
    int i;
    for (i = 0; i < 16; i++)
      send_item(ACT_CREATE, 32'd1, (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : $urandom,
                4'($urandom));
    send_item(ACT_CREATE, 32'd7, $urandom, 4'd0);
    send_item(ACT_DELETE, $urandom, $urandom, 4'hF);
    // Slot 15 gets the largest deadline, so it outlives the mass expiry.
    send_item(ACT_CREATE, 32'hFFFF_FFFF, 32'd0, 4'd0);
    send_item(ACT_TICK, $urandom, $urandom, 4'($urandom));
    drain_pool();
    send_item(ACT_DELETE, 32'd0, 32'd0, 4'hF);
    send_item(ACT_DELETE, 32'd0, 32'd0, 4'hF);
    drain_pool();
  endtask

  // Random traffic in bursts: mostly near-term timers, with far, past and zero deadlines.
  task automatic test_random_traffic(input int items);
    int          left;
    int          burst;
    int          b;
    int          pick;
    int          r;
    int          i;
    logic [3:0]  sl;
    logic [31:0] dl;
    logic [31:0] tg;
    left = items;
    while (left > 0) begin
      burst = $urandom_range(1, 10);
      for (b = 0; b < burst && left > 0; b++) begin
        pick = $urandom_range(0, 99);
        r    = $urandom_range(0, 19);
        tg   = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        sl   = 4'($urandom);
        if (pick < 40) begin
          r = $urandom_range(0, 99);
          if (r < 70)      dl = shadow_ticks + 32'($urandom_range(1, 6));
          else if (r < 85) dl = $urandom;
          else if (r < 95) dl = 32'($urandom_range(0, shadow_ticks));
          else             dl = 32'd0;
          send_item(ACT_CREATE, dl, tg, sl);
        end else if (pick < 60) begin
          // Mostly delete a live timer; otherwise any slot.
          if ($urandom_range(0, 3) != 0) begin
            r = $urandom_range(0, 15);
            for (i = 0; i < 16; i++)
              if (shadow_valid[4'((r + i) % 16)]) sl = 4'((r + i) % 16);
          end
          send_item(ACT_DELETE, $urandom, tg, sl);
        end else if (pick < 95) begin
          send_item(ACT_TICK, $urandom, tg, sl);
        end else begin
          send_item(ACT_NONE, $urandom, tg, sl);
        end
        left--;
      end
      r = $urandom_range(0, 9);
      if (r == 0)     drain_pool();
      else if (r > 3) idle_cycles($urandom_range(1, 25));
    end
    drain_pool();
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    action       = ACT_NONE;
    deadline     = 32'd0;
    tag          = 32'd0;
    slot         = 4'd0;
    fail_count   = 0;
    shadow_ticks = 32'd0;
    shadow_valid = 16'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_refusals();
    test_full_pool();
    test_random_traffic(220);

    // Allow a full tick scan for stray beats after the last one owed.
    repeat (40) @(negedge clk);
    fail_count += beats_owed.size();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/otp_pkg.sv
rtl/otp_slot_store.sv
rtl/one_shot_timer_pool_top.sv
sim/tb.sv
